>>> rtl/wcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_pkg: shared types and constants for the WAV chunk parser
// Item structs, parse phases, status codes and control/status bundles.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SUM_W            = 20;  // channel sum, signed
  localparam int DVD_W            = 28;  // |sum| * 256
  localparam int DIV_CNT_W        = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] MIN_LEN  = 32'd44;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_FORMAT   = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;
  localparam logic [2:0] ST_CHANNELS = 3'd5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    PH_RIFF   = 4'd0,
    PH_HEADER = 4'd1,
    PH_SKIP   = 4'd2,
    PH_FMT    = 4'd3,
    PH_DATA   = 4'd4,
    PH_PAD    = 4'd5,
    PH_STOP   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_DIV     = 2'd1,
    S_OUT_SMP = 2'd2,
    S_OUT_STS = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] sample_value;
    logic [2:0]         status;
    logic [15:0]        format_code;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [30:0]        frame_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic step;     // parse the incoming byte
    logic div_run;  // one divider iteration
    logic sel_sts;  // present the status result
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;  // this byte completes a frame
    logic eof;         // this byte ends the file
    logic div_last;    // last divider iteration
    logic eof_pend;    // a status follows the sample
  } dp_stat_t;

  function automatic logic [7:0] riff_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h52;
      2'd1:    r = 8'h49;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h41;
      2'd2:    r = 8'h56;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/wav_chunk_parser_downmix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_chunk_parser_downmix: RIFF/WAVE chunk walker with channel down-mix
// Parses a WAV file byte by byte, emits averaged samples and a final status.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  wcp_pkg::in_item_t
//   out       output     out_valid/out_stall  wcp_pkg::out_item_t
//   cfg       input      cfg_we               file_length (32 bit)
//
// A byte that completes no frame and ends no file leaves the block idle.
// A byte that completes a frame starts the serial divider on the sum
// (one quotient bit per cycle), then the sample is held until taken.
// On the final byte the status item follows any sample; the block then
// takes the next byte. No clearing pass after reset; out_stall holds the
// result and blocks new input until it is taken.
// ----------------------------------------------------------------------------
module wav_chunk_parser_downmix #(
  parameter int MAX_CHANNELS = wcp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wcp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wcp_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  wcp_pkg::ctrl_cmd_t cmd;
  wcp_pkg::dp_stat_t  stat;

  wcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wcp_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/wcp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_ctrl: sequencing FSM
// Takes a byte, runs the divider on a finished frame, hands out results.
// ----------------------------------------------------------------------------
module wcp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  wcp_pkg::dp_stat_t    stat_i,
  output wcp_pkg::ctrl_cmd_t   cmd_o
);

  wcp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      wcp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (stat_i.frame_done) begin
            state_d = wcp_pkg::S_DIV;
          end else if (stat_i.eof) begin
            state_d = wcp_pkg::S_OUT_STS;
          end
        end
      end
      wcp_pkg::S_DIV: begin
        cmd_o.div_run = 1'b1;
        if (stat_i.div_last) begin
          state_d = wcp_pkg::S_OUT_SMP;
        end
      end
      wcp_pkg::S_OUT_SMP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = stat_i.eof_pend ? wcp_pkg::S_OUT_STS : wcp_pkg::S_IDLE;
        end
      end
      wcp_pkg::S_OUT_STS: begin
        out_valid_o   = 1'b1;
        cmd_o.sel_sts = 1'b1;
        if (!out_stall_i) begin
          state_d = wcp_pkg::S_IDLE;
        end
      end
      default: state_d = wcp_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/wcp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_datapath: parse state, down-mix accumulator and serial divider
// One byte is parsed per step command; the divider retires one bit a cycle.
// ----------------------------------------------------------------------------
module wcp_datapath #(
  parameter int MAX_CHANNELS = wcp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  wcp_pkg::in_item_t    in_item_i,
  input  wcp_pkg::ctrl_cmd_t   cmd_i,
  output wcp_pkg::dp_stat_t    stat_o,
  output wcp_pkg::out_item_t   out_item_o
);

  localparam int DVS_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [15:0] MAX_CH = 16'(MAX_CHANNELS);

  logic [31:0]             flen_q;
  logic [31:0]             pos_q, pos_d;
  wcp_pkg::phase_e         phase_q, phase_d;
  logic [31:0]             tag_q, tag_d;
  logic [31:0]             cbl_q, cbl_d;
  logic                    pad_q, pad_d;
  logic [15:0]             ftag_q, ftag_d;
  logic [15:0]             ch_q, ch_d;
  logic [31:0]             rate_q, rate_d;
  logic [15:0]             bits_q, bits_d;
  logic                    found_q, found_d;
  logic signed [wcp_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [15:0]             idx_q, idx_d;
  logic [7:0]              low_q, low_d;
  logic [30:0]             frames_q, frames_d;
  logic [2:0]              err_q, err_d;
  logic [4:0]              off_q, off_d;
  logic                    eofp_q, eofp_d;

  // result snapshots
  wcp_pkg::out_item_t      smp_q, smp_d, sts_q, sts_d;

  // divider
  logic [wcp_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [DVS_W:0]                rem_q, rem_d;
  logic [DVS_W-1:0]              dvs_q, dvs_d;
  logic                          neg_q, neg_d;
  logic [wcp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic                    frame_done;
  logic [7:0]              b;
  logic signed [15:0]      v;
  logic signed [wcp_pkg::SUM_W-1:0] sum_new;
  logic [wcp_pkg::SUM_W-1:0] mag;
  logic [15:0]             idx_new;
  logic [DVS_W:0]          rem_sh;
  logic [2:0]              st;
  logic [23:0]             quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q   <= '0;
      pos_q    <= '0;
      phase_q  <= wcp_pkg::PH_RIFF;
      tag_q    <= '0;
      cbl_q    <= '0;
      pad_q    <= 1'b0;
      ftag_q   <= '0;
      ch_q     <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      found_q  <= 1'b0;
      sum_q    <= '0;
      idx_q    <= '0;
      low_q    <= '0;
      frames_q <= '0;
      err_q    <= '0;
      off_q    <= '0;
      eofp_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        flen_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      cbl_q    <= cbl_d;
      pad_q    <= pad_d;
      ftag_q   <= ftag_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      found_q  <= found_d;
      sum_q    <= sum_d;
      idx_q    <= idx_d;
      low_q    <= low_d;
      frames_q <= frames_d;
      err_q    <= err_d;
      off_q    <= off_d;
      eofp_q   <= eofp_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    sts_q <= sts_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  always_comb begin
    pos_d = pos_q;   phase_d = phase_q; tag_d = tag_q;   cbl_d = cbl_q;
    pad_d = pad_q;   ftag_d = ftag_q;   ch_d = ch_q;     rate_d = rate_q;
    bits_d = bits_q; found_d = found_q; sum_d = sum_q;   idx_d = idx_q;
    low_d = low_q;   frames_d = frames_q; err_d = err_q; off_d = off_q;
    eofp_d = eofp_q; smp_d = smp_q;     sts_d = sts_q;
    frame_done = 1'b0;
    b       = in_item_i.file_byte;
    v       = signed'({b, low_q});
    sum_new = sum_q + {{(wcp_pkg::SUM_W-16){v[15]}}, v};
    idx_new = idx_q + 16'd1;
    mag     = sum_new[wcp_pkg::SUM_W-1] ? wcp_pkg::SUM_W'(-sum_new)
                                        : wcp_pkg::SUM_W'(sum_new);
    st      = wcp_pkg::ST_OK;

    if (cmd_i.step) begin
      if (phase_q == wcp_pkg::PH_RIFF) begin
        if (pos_q == 32'd0 && flen_q < wcp_pkg::MIN_LEN) begin
          err_d   = wcp_pkg::ST_SHORT;
          phase_d = wcp_pkg::PH_STOP;
        end else if (pos_q < 32'd4) begin
          if (b != wcp_pkg::riff_byte(pos_q[1:0])) begin
            err_d   = wcp_pkg::ST_MAGIC;
            phase_d = wcp_pkg::PH_STOP;
          end
        end else if (pos_q >= 32'd8 && pos_q < 32'd12) begin
          if (b != wcp_pkg::wave_byte(pos_q[1:0])) begin
            err_d   = wcp_pkg::ST_MAGIC;
            phase_d = wcp_pkg::PH_STOP;
          end else if (pos_q == 32'd11) begin
            phase_d = wcp_pkg::PH_HEADER;
            off_d   = '0;
          end
        end
      end else if (phase_q == wcp_pkg::PH_STOP) begin
        phase_d = wcp_pkg::PH_STOP;
      end else if (pos_q >= flen_q) begin
        phase_d = wcp_pkg::PH_STOP;
      end else begin
        unique case (phase_q)
          wcp_pkg::PH_HEADER: begin
            if (off_q == 5'd0 && ({1'b0, pos_q} + 33'd8 > {1'b0, flen_q})) begin
              phase_d = wcp_pkg::PH_STOP;
            end else begin
              if (off_q == 5'd0) tag_d = '0;
              if (off_q == 5'd4) cbl_d = '0;
              if (off_q < 5'd4) tag_d[off_q[1:0]*8 +: 8] = b;
              else              cbl_d[off_q[1:0]*8 +: 8] = b;
              off_d = off_q + 5'd1;
              if (off_q == 5'd7) begin
                if ({2'b0, pos_q} + 34'd1 + {2'b0, cbl_d} > {2'b0, flen_q}) begin
                  phase_d = wcp_pkg::PH_STOP;
                end else begin
                  pad_d = cbl_d[0];
                  off_d = '0;
                  if (tag_d == wcp_pkg::TAG_FMT && cbl_d >= wcp_pkg::FMT_MIN &&
                      !found_q) begin
                    phase_d = wcp_pkg::PH_FMT;
                  end else if (tag_d == wcp_pkg::TAG_DATA && !found_q &&
                               ftag_q == 16'd1 && bits_q == 16'd16 &&
                               ch_q != 16'd0 && ch_q <= MAX_CH) begin
                    found_d = 1'b1;
                    sum_d   = '0;
                    idx_d   = '0;
                    phase_d = wcp_pkg::PH_DATA;
                  end else begin
                    phase_d = wcp_pkg::PH_SKIP;
                  end
                  if (cbl_d == 32'd0) begin
                    sum_d   = '0;
                    idx_d   = '0;
                    phase_d = wcp_pkg::PH_HEADER;
                  end
                end
              end
            end
          end
          wcp_pkg::PH_PAD: begin
            phase_d = wcp_pkg::PH_HEADER;
            off_d   = '0;
          end
          wcp_pkg::PH_SKIP, wcp_pkg::PH_FMT, wcp_pkg::PH_DATA: begin
            if (phase_q == wcp_pkg::PH_FMT) begin
              case (off_q)
                5'd0:  ftag_d[7:0]  = b;
                5'd1:  ftag_d[15:8] = b;
                5'd2:  ch_d[7:0]    = b;
                5'd3:  ch_d[15:8]   = b;
                5'd4, 5'd5, 5'd6, 5'd7: rate_d[off_q[1:0]*8 +: 8] = b;
                5'd14: bits_d[7:0]  = b;
                5'd15: bits_d[15:8] = b;
                default: ;
              endcase
              if (off_q < 5'd16) off_d = off_q + 5'd1;
            end else if (phase_q == wcp_pkg::PH_DATA) begin
              if (off_q == 5'd0) begin
                low_d = b;
                off_d = 5'd1;
              end else begin
                off_d = '0;
                if (idx_new >= ch_q && ch_q != 16'd0) begin
                  frame_done = 1'b1;
                  if (frames_q != 31'h7FFF_FFFF) frames_d = frames_q + 31'd1;
                  sum_d = '0;
                  idx_d = '0;
                end else begin
                  sum_d = sum_new;
                  idx_d = idx_new;
                end
              end
            end
            cbl_d = cbl_q - 32'd1;
            if (cbl_d == 32'd0) begin
              off_d   = '0;
              sum_d   = '0;
              idx_d   = '0;
              phase_d = pad_q ? wcp_pkg::PH_PAD : wcp_pkg::PH_HEADER;
            end
          end
          default: phase_d = wcp_pkg::PH_STOP;
        endcase
      end

      if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;

      if (err_d != 3'd0)                                       st = err_d;
      else if (pos_q < 32'd11 || phase_d == wcp_pkg::PH_RIFF)  st = wcp_pkg::ST_SHORT;
      else if (found_d)                                        st = wcp_pkg::ST_OK;
      else if (ftag_d != 16'd1 || bits_d != 16'd16 || ch_d == 16'd0)
                                                               st = wcp_pkg::ST_FORMAT;
      else if (ch_d > MAX_CH)                                  st = wcp_pkg::ST_CHANNELS;
      else                                                     st = wcp_pkg::ST_NO_DATA;

      smp_d.result_kind   = wcp_pkg::KIND_SAMPLE;
      smp_d.sample_value  = '0;
      smp_d.status        = wcp_pkg::ST_OK;
      smp_d.format_code   = ftag_d;
      smp_d.rate_hz       = rate_d;
      smp_d.channel_count = ch_d;
      smp_d.frame_count   = frames_d;
      smp_d.last          = 1'b0;

      sts_d.result_kind   = wcp_pkg::KIND_STATUS;
      sts_d.sample_value  = '0;
      sts_d.status        = st;
      sts_d.format_code   = ftag_d;
      sts_d.rate_hz       = rate_d;
      sts_d.channel_count = ch_d;
      sts_d.frame_count   = frames_d;
      sts_d.last          = 1'b1;

      eofp_d = in_item_i.end_of_file;
      if (in_item_i.end_of_file) begin
        // new file starts with the next byte
        pos_d = '0;   phase_d = wcp_pkg::PH_RIFF; tag_d = '0;  cbl_d = '0;
        pad_d = 1'b0; ftag_d = '0; ch_d = '0;     rate_d = '0; bits_d = '0;
        found_d = 1'b0; sum_d = '0; idx_d = '0;   low_d = '0;  frames_d = '0;
        err_d = '0;   off_d = '0;
      end
    end
  end

  // restoring divider: quotient bits shift into the dividend register
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_sh = {rem_q[DVS_W-1:0], dvd_q[wcp_pkg::DVD_W-1]};
    if (cmd_i.step && frame_done) begin
      dvd_d = {mag, 8'd0};
      rem_d = '0;
      dvs_d = ch_q[DVS_W-1:0];
      neg_d = sum_new[wcp_pkg::SUM_W-1];
      cnt_d = '0;
    end else if (cmd_i.div_run) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        dvd_d = {dvd_q[wcp_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[wcp_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + wcp_pkg::DIV_CNT_W'(1);
    end
  end

  assign quo = dvd_q[23:0];

  always_comb begin
    if (cmd_i.sel_sts) begin
      out_item_o = sts_q;
    end else begin
      out_item_o              = smp_q;
      out_item_o.sample_value = neg_q ? signed'(24'd0 - quo) : signed'(quo);
    end
  end

  assign stat_o.frame_done = frame_done;
  assign stat_o.eof        = in_item_i.end_of_file;
  assign stat_o.div_last   = (cnt_q == wcp_pkg::DIV_LAST);
  assign stat_o.eof_pend   = eofp_q;

endmodule

>>> rtl/wcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_checker: port-level checks for the WAV chunk parser
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module wcp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wcp_pkg::out_item_t out_item_o
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // status items close the file, samples never do
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.result_kind == wcp_pkg::KIND_STATUS) == out_item_o.last)
    else $error("last flag does not match result kind");

  a_sample_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == wcp_pkg::KIND_SAMPLE
    |-> out_item_o.status == wcp_pkg::ST_OK)
    else $error("sample item carries a status");

  // no byte is taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

endmodule

bind wav_chunk_parser_downmix wcp_checker u_wcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
